### design/vpv_pkg.sv
// Shared types, constants and helpers for the vertex projection and viewport block.
package vpv_pkg;

  // Field formats
  localparam int COORD_WIDTH      = 24;
  localparam int COORD_FRAC_BITS  = 12;
  localparam int MATRIX_FRAC_BITS = 12;
  localparam int OUT_WIDTH        = 24;
  localparam int ENTRY_W          = 16;
  localparam int SIZE_W           = 12;
  localparam int VP_SHIFT         = 7;

  // Datapath widths
  localparam int PROD_W = COORD_WIDTH + ENTRY_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int QB     = OUT_WIDTH;
  localparam int REM_W  = SUM_W + QB;

  // Pipeline: product, sum, magnitude, numerator, QB+1 divide stages, output
  localparam int NST = QB + 6;

  // Configuration port
  localparam int CFG_W  = 64;
  localparam int ADDR_W = 6;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_ROW0   = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW1   = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW2   = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW3   = 3'd3;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd4;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd5;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 12'd256;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 12'd240;

  localparam logic signed [QB+1:0] OUT_MAX = (QB+2)'(2**(OUT_WIDTH-1) - 1);
  localparam logic signed [QB+1:0] OUT_MIN = (QB+2)'(-(2**(OUT_WIDTH-1)));

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic signed [COORD_WIDTH-1:0] vertex_z;
  } vertex_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] screen_x;
    logic signed [OUT_WIDTH-1:0] screen_y;
    logic signed [OUT_WIDTH-1:0] depth_z;
    logic                        w_was_zero;
    logic                        saturated;
  } result_t;

  // One divide stage word: three lanes share the divisor
  typedef struct packed {
    logic [REM_W-1:0] rx;
    logic [REM_W-1:0] ry;
    logic [REM_W-1:0] rz;
    logic [QB-1:0]    qx;
    logic [QB-1:0]    qy;
    logic [QB-1:0]    qz;
    logic             bx;
    logic             by;
    logic             bz;
    logic             nx;
    logic             ny;
    logic             nz;
    logic             wz;
    logic [SUM_W-1:0] dv;
  } div_t;

  typedef struct packed {
    logic                        sat;
    logic signed [OUT_WIDTH-1:0] val;
  } clamp_t;

  // Clip to the output range; big means the quotient overflowed QB bits
  function automatic clamp_t clamp_out(input logic signed [QB+1:0] v,
                                       input logic big, input logic neg);
    clamp_t res;
    res.sat = 1'b0;
    res.val = v[OUT_WIDTH-1:0];
    if (big) begin
      res.sat = 1'b1;
      res.val = neg ? OUT_MIN[OUT_WIDTH-1:0] : OUT_MAX[OUT_WIDTH-1:0];
    end else if (v > OUT_MAX) begin
      res.sat = 1'b1;
      res.val = OUT_MAX[OUT_WIDTH-1:0];
    end else if (v < OUT_MIN) begin
      res.sat = 1'b1;
      res.val = OUT_MIN[OUT_WIDTH-1:0];
    end
    return res;
  endfunction

endpackage

### design/vertex_project_viewport_core.sv
// Vertex projection: 4x4 matrix transform, perspective divide and viewport map.
//
//  channel | direction | handshake                    | word
//  in_     | input     | in_valid / in_stall          | vpv_pkg::vertex_t
//  out_    | output    | out_valid / out_stall        | vpv_pkg::result_t
//  config  | input     | psel/penable/pwrite, pready  | 64-bit registers at 8*i
//
//  One vertex per cycle while out_stall is low. Stages: product, sum,
//  magnitude, numerator, overflow check, 24 restoring divide stages of one
//  quotient bit each, output register. The divide pipeline sets the latency.
//  Synchronous reset clears valid bits and matrix rows; screen is 256x240.
//  Each stage holds its word while the next stage is full and stalled, so an
//  empty stage further on keeps input flowing while a result waits.
module vertex_project_viewport_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  vpv_pkg::vertex_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output vpv_pkg::result_t                    out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vpv_pkg::ADDR_W-1:0]          paddr,
  input  logic [vpv_pkg::CFG_W-1:0]           pwdata,
  output logic [vpv_pkg::CFG_W-1:0]           prdata,
  output logic                                pready
);

  // Configuration registers
  logic [vpv_pkg::CFG_W-1:0]  mat_r [4];
  logic [vpv_pkg::SIZE_W-1:0] scr_w_r;
  logic [vpv_pkg::SIZE_W-1:0] scr_h_r;
  logic                       cfg_wr;
  logic [vpv_pkg::IDX_W-1:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[vpv_pkg::ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[0] <= '0;
      mat_r[1] <= '0;
      mat_r[2] <= '0;
      mat_r[3] <= '0;
      scr_w_r  <= vpv_pkg::WIDTH_RST;
      scr_h_r  <= vpv_pkg::HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        vpv_pkg::REG_ROW0:   mat_r[0] <= pwdata;
        vpv_pkg::REG_ROW1:   mat_r[1] <= pwdata;
        vpv_pkg::REG_ROW2:   mat_r[2] <= pwdata;
        vpv_pkg::REG_ROW3:   mat_r[3] <= pwdata;
        vpv_pkg::REG_WIDTH:  scr_w_r  <= pwdata[vpv_pkg::SIZE_W-1:0];
        vpv_pkg::REG_HEIGHT: scr_h_r  <= pwdata[vpv_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      vpv_pkg::REG_ROW0:   prdata = mat_r[0];
      vpv_pkg::REG_ROW1:   prdata = mat_r[1];
      vpv_pkg::REG_ROW2:   prdata = mat_r[2];
      vpv_pkg::REG_ROW3:   prdata = mat_r[3];
      vpv_pkg::REG_WIDTH:  prdata = vpv_pkg::CFG_W'(scr_w_r);
      vpv_pkg::REG_HEIGHT: prdata = vpv_pkg::CFG_W'(scr_h_r);
      default:             prdata = '0;
    endcase
  end

  // Matrix entries, signed 16-bit, column c at bits 16c
  logic signed [vpv_pkg::ENTRY_W-1:0] ent [4][4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        ent[r][c] = mat_r[r][vpv_pkg::ENTRY_W*c +: vpv_pkg::ENTRY_W];
      end
    end
  end

  // Valid bits and back-pressure chain
  logic [vpv_pkg::NST-1:0] vld_r;
  logic [vpv_pkg::NST-1:0] rdy;

  always_comb begin
    rdy[vpv_pkg::NST-1] = !vld_r[vpv_pkg::NST-1] || !out_stall;
    for (int k = vpv_pkg::NST-2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < vpv_pkg::NST; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage 0: products of coordinates and the first three rows
  logic signed [vpv_pkg::PROD_W-1:0] prod_r [3][4];
  logic signed [vpv_pkg::COORD_WIDTH-1:0] vin [3];
  assign vin[0] = in_data.vertex_x;
  assign vin[1] = in_data.vertex_y;
  assign vin[2] = in_data.vertex_z;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_r[r][c] <= vin[r] * ent[r][c];
        end
      end
    end
  end

  // Stage 1: column sums with the translation row at coordinate scale
  logic signed [vpv_pkg::SUM_W-1:0] sum_r [4];
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int c = 0; c < 4; c++) begin
        sum_r[c] <= vpv_pkg::SUM_W'(prod_r[0][c]) + vpv_pkg::SUM_W'(prod_r[1][c])
                  + vpv_pkg::SUM_W'(prod_r[2][c])
                  + (vpv_pkg::SUM_W'(ent[3][c]) <<< vpv_pkg::COORD_FRAC_BITS);
      end
    end
  end

  // Stage 2: magnitudes, quotient signs and divisor
  logic [vpv_pkg::SUM_W-1:0] mag_r [3];
  logic [vpv_pkg::SUM_W-1:0] mdv_r;
  logic [2:0]                mneg_r;
  logic                      mwz_r;
  logic                      wz_c;

  assign wz_c = (sum_r[3] == '0);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int c = 0; c < 3; c++) begin
        mag_r[c]  <= sum_r[c][vpv_pkg::SUM_W-1] ? -sum_r[c] : sum_r[c];
        mneg_r[c] <= sum_r[c][vpv_pkg::SUM_W-1] ^ sum_r[3][vpv_pkg::SUM_W-1];
      end
      mwz_r <= wz_c;
      if (wz_c) begin
        mdv_r <= vpv_pkg::SUM_W'(1) << (vpv_pkg::COORD_FRAC_BITS + vpv_pkg::MATRIX_FRAC_BITS);
      end else begin
        mdv_r <= sum_r[3][vpv_pkg::SUM_W-1] ? -sum_r[3] : sum_r[3];
      end
    end
  end

  // Stage 3: scaled numerators
  logic [vpv_pkg::SUM_W+vpv_pkg::SIZE_W-1:0] px_c;
  logic [vpv_pkg::SUM_W+vpv_pkg::SIZE_W-1:0] py_c;
  logic [vpv_pkg::REM_W-1:0] num_r [3];
  logic [vpv_pkg::SUM_W-1:0] ndv_r;
  logic [2:0]                nneg_r;
  logic                      nwz_r;

  assign px_c = mag_r[0] * scr_w_r;
  assign py_c = mag_r[1] * scr_h_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      num_r[0] <= vpv_pkg::REM_W'(px_c) << vpv_pkg::VP_SHIFT;
      num_r[1] <= vpv_pkg::REM_W'(py_c) << vpv_pkg::VP_SHIFT;
      num_r[2] <= vpv_pkg::REM_W'(mag_r[2]) << vpv_pkg::COORD_FRAC_BITS;
      ndv_r    <= mdv_r;
      nneg_r   <= mneg_r;
      nwz_r    <= mwz_r;
    end
  end

  // Divide stage 0: overflow check against divisor << QB
  vpv_pkg::div_t div_r [vpv_pkg::QB+1];
  logic [vpv_pkg::REM_W-1:0] dtop_c;
  assign dtop_c = vpv_pkg::REM_W'(ndv_r) << vpv_pkg::QB;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      div_r[0].rx <= num_r[0];
      div_r[0].ry <= num_r[1];
      div_r[0].rz <= num_r[2];
      div_r[0].qx <= '0;
      div_r[0].qy <= '0;
      div_r[0].qz <= '0;
      div_r[0].bx <= (num_r[0] >= dtop_c);
      div_r[0].by <= (num_r[1] >= dtop_c);
      div_r[0].bz <= (num_r[2] >= dtop_c);
      div_r[0].nx <= nneg_r[0];
      div_r[0].ny <= nneg_r[1];
      div_r[0].nz <= nneg_r[2];
      div_r[0].wz <= nwz_r;
      div_r[0].dv <= ndv_r;
    end
  end

  // Restoring divide, one quotient bit per stage, MSB first
  for (genvar k = 1; k <= vpv_pkg::QB; k++) begin : g_div
    logic [vpv_pkg::REM_W-1:0] sh;
    logic gx, gy, gz;
    vpv_pkg::div_t dnxt;

    always_comb begin
      sh   = vpv_pkg::REM_W'(div_r[k-1].dv) << (vpv_pkg::QB - k);
      gx   = (div_r[k-1].rx >= sh);
      gy   = (div_r[k-1].ry >= sh);
      gz   = (div_r[k-1].rz >= sh);
      dnxt = div_r[k-1];
      dnxt.rx = gx ? div_r[k-1].rx - sh : div_r[k-1].rx;
      dnxt.ry = gy ? div_r[k-1].ry - sh : div_r[k-1].ry;
      dnxt.rz = gz ? div_r[k-1].rz - sh : div_r[k-1].rz;
      dnxt.qx = {div_r[k-1].qx[vpv_pkg::QB-2:0], gx};
      dnxt.qy = {div_r[k-1].qy[vpv_pkg::QB-2:0], gy};
      dnxt.qz = {div_r[k-1].qz[vpv_pkg::QB-2:0], gz};
    end

    always_ff @(posedge clk) begin
      if (rdy[4+k]) div_r[k] <= dnxt;
    end
  end

  // Output stage: sign, viewport offset and clipping
  vpv_pkg::div_t                  dl;
  logic signed [vpv_pkg::QB+1:0]  qx_s, qy_s, qz_s;
  logic signed [vpv_pkg::QB+1:0]  offx, offy;
  vpv_pkg::clamp_t                cx, cy, cz;
  vpv_pkg::result_t               res_nxt;
  vpv_pkg::result_t               res_r;

  assign dl = div_r[vpv_pkg::QB];

  always_comb begin
    qx_s = signed'({2'b00, dl.qx});
    qy_s = signed'({2'b00, dl.qy});
    qz_s = signed'({2'b00, dl.qz});
    if (dl.nx) qx_s = -qx_s;
    if (dl.ny) qy_s = -qy_s;
    if (dl.nz) qz_s = -qz_s;
    offx = signed'((vpv_pkg::QB+2)'({scr_w_r, {vpv_pkg::VP_SHIFT{1'b0}}}));
    offy = signed'((vpv_pkg::QB+2)'({scr_h_r, {vpv_pkg::VP_SHIFT{1'b0}}}));
    cx = vpv_pkg::clamp_out(qx_s + offx, dl.bx, dl.nx);
    cy = vpv_pkg::clamp_out(qy_s + offy, dl.by, dl.ny);
    cz = vpv_pkg::clamp_out(qz_s, dl.bz, dl.nz);
    res_nxt.screen_x   = cx.val;
    res_nxt.screen_y   = cy.val;
    res_nxt.depth_z    = cz.val;
    res_nxt.w_was_zero = dl.wz;
    res_nxt.saturated  = cx.sat | cy.sat | cz.sat;
  end

  always_ff @(posedge clk) begin
    if (rdy[vpv_pkg::NST-1]) res_r <= res_nxt;
  end

  assign out_valid = vld_r[vpv_pkg::NST-1];
  assign out_data  = res_r;

endmodule

### design/vpv_checker.sv
// Port-level checks for the vertex projection core, bound to the top level.
module vpv_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input vpv_pkg::result_t out_data
);

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown straight after reset");

  // With the output free, every stage can move, so input is never held off
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // A stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result word changed under stall");

endmodule

bind vertex_project_viewport_core vpv_checker u_vpv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
